### rtl/ltws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltws_pkg: shared types and constants
// Opcodes, widths and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package ltws_pkg;
    localparam int MaxThreads = 16;
    localparam int IdxW = $clog2(MaxThreads);
    localparam int CntW = $clog2(MaxThreads + 1);
    localparam int KeyW = 64;
    localparam int IdW = 4;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_SLEEP = 3'd1;
    localparam logic [2:0] OP_AWAKE = 3'd2;
    localparam logic [2:0] OP_RMINUS = 3'd3;
    localparam logic [2:0] OP_RPLUS = 3'd4;
    localparam logic [2:0] OP_CHANGED = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [IdW-1:0] thread_id;
        logic [KeyW-1:0] instr_count;
    } in_t;

    typedef struct packed {
        logic slept;
        logic woke_valid;
        logic [IdW-1:0] woke_thread;
        logic min_changed;
        logic is_empty;
        logic queue_full;
        logic [CntW-1:0] running_now;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic done;
    } stat_t;
endpackage

### rtl/ltws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltws_in_if / ltws_out_if: valid/ready channels
// Input operation and result channels.
// ----------------------------------------------------------------------------
interface ltws_in_if import ltws_pkg::*; ();
    logic valid;
    logic ready;
    logic [2:0] op;
    logic [IdW-1:0] thread_id;
    logic [KeyW-1:0] instr_count;
    modport source (output valid, op, thread_id, instr_count, input ready);
    modport sink (input valid, op, thread_id, instr_count, output ready);
endinterface

interface ltws_out_if import ltws_pkg::*; ();
    logic valid;
    logic ready;
    logic slept;
    logic woke_valid;
    logic [IdW-1:0] woke_thread;
    logic min_changed;
    logic is_empty;
    logic queue_full;
    logic [CntW-1:0] running_now;
    modport source (output valid, slept, woke_valid, woke_thread, min_changed,
                    is_empty, queue_full, running_now, input ready);
    modport sink (input valid, slept, woke_valid, woke_thread, min_changed,
                  is_empty, queue_full, running_now, output ready);
endinterface

### rtl/ltws_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltws_datapath: sorted cell chain and counters
// Each cell compares its key with the new key; insert and pop shift in place.
// ----------------------------------------------------------------------------
module ltws_datapath
    import ltws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  in_t   item,
    output out_t  res,
    output stat_t stat
);
    logic [KeyW-1:0] key_reg [MaxThreads];
    logic [IdW-1:0] id_reg [MaxThreads];
    logic [CntW-1:0] len_reg, len_next;
    logic [CntW-1:0] run_reg, run_next;
    logic [KeyW-1:0] cmin_reg, cmin_next;
    logic [KeyW-1:0] rmin_reg, rmin_next;

    logic full, empty, do_put, do_pop;
    logic [MaxThreads-1:0] ge; // slot key >= new key (insert before it)
    logic [MaxThreads-1:0] ge_prev; // ge of the cell to the left, 0 at the head
    out_t r;

    assign full = (len_reg == CntW'(MaxThreads));
    assign empty = (len_reg == '0);
    assign ge_prev = {ge[MaxThreads-2:0], 1'b0};

    always_comb
    begin
        for (int i = 0; i < MaxThreads; i++)
        begin
            ge[i] = (CntW'(i) >= len_reg) || (key_reg[i] >= item.instr_count);
        end
    end

    always_comb
    begin
        r = '0;
        do_put = 1'b0;
        do_pop = 1'b0;
        len_next = len_reg;
        run_next = run_reg;
        cmin_next = cmin_reg;
        rmin_next = rmin_reg;
        case (item.op)
            OP_INSERT:
            begin
                if (full) r.queue_full = 1'b1;
                else do_put = 1'b1;
            end
            OP_SLEEP:
            begin
                if (run_reg == CntW'(1) && (empty || item.instr_count <= key_reg[0]))
                    cmin_next = item.instr_count;
                else if (full)
                    r.queue_full = 1'b1;
                else
                begin
                    if (run_reg != '0) run_next = run_reg - 1'b1;
                    do_put = 1'b1;
                    r.slept = 1'b1;
                end
            end
            OP_AWAKE:
            begin
                if (!empty && (run_reg == '0 || cmin_reg >= key_reg[0]))
                begin
                    if (run_reg == '0) cmin_next = key_reg[0];
                    do_pop = 1'b1;
                    r.woke_valid = 1'b1;
                    r.woke_thread = id_reg[0];
                    if (run_reg != CntW'(MaxThreads)) run_next = run_reg + 1'b1;
                end
            end
            OP_RMINUS: if (run_reg != '0) run_next = run_reg - 1'b1;
            OP_RPLUS: if (run_reg != CntW'(MaxThreads)) run_next = run_reg + 1'b1;
            OP_CHANGED:
            begin
                r.min_changed = (cmin_reg != rmin_reg);
                rmin_next = cmin_reg;
            end
            default: ;
        endcase
        if (do_put) len_next = len_reg + 1'b1;
        if (do_pop) len_next = len_reg - 1'b1;
        r.is_empty = (run_next == '0) && (len_next == '0);
        r.running_now = run_next;
    end

    // cell chain: shift right from insert point, or left on pop
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (do_put)
            begin
                for (int i = 0; i < MaxThreads; i++)
                begin
                    if (ge[i] && !ge_prev[i])
                    begin
                        key_reg[i] <= item.instr_count;
                        id_reg[i] <= item.thread_id;
                    end
                    else if (ge_prev[i])
                    begin
                        key_reg[i] <= key_reg[(i == 0) ? 0 : i-1];
                        id_reg[i] <= id_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end
            else if (do_pop)
            begin
                for (int i = 0; i < MaxThreads - 1; i++)
                begin
                    key_reg[i] <= key_reg[i+1];
                    id_reg[i] <= id_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            run_reg <= '0;
            cmin_reg <= '0;
            rmin_reg <= '0;
            res <= '0;
            stat <= '0;
        end
        else
        begin
            stat.done <= cmd.exec;
            if (cmd.exec)
            begin
                len_reg <= len_next;
                run_reg <= run_next;
                cmin_reg <= cmin_next;
                rmin_reg <= rmin_next;
                res <= r;
            end
        end
    end
endmodule

### rtl/ltws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltws_ctrl: handshake controller
// Accepts a transaction, holds the result until taken.
// ----------------------------------------------------------------------------
module ltws_ctrl
    import ltws_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;
    logic state_reg, state_next;

    // take a new item when the result slot is empty or being drained
    assign in_ready = (state_reg == S_IDLE) || out_ready;
    assign cmd.exec = in_valid && in_ready;
    assign out_valid = (state_reg == S_HOLD);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (cmd.exec) state_next = S_HOLD;
            S_HOLD: if (out_ready && !cmd.exec) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule

### rtl/lockstep_thread_wake_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lockstep_thread_wake_scheduler: sorted wait queue with running counter
// Top level joining the handshake controller and the cell-chain datapath.
// ----------------------------------------------------------------------------
// Each operation transaction gives exactly one result transaction. The wait
// queue is a chain of sixteen cells that all compare with the new key at
// once, so an insert or a pop shifts the chain in place. Results sit in an
// output register, and a new operation is taken in the same cycle the held
// result is drained, so one operation per cycle is sustained while the sink
// keeps ready high.
// Queue entries hold no reset value; only occupied slots are ever read.
module lockstep_thread_wake_scheduler
    import ltws_pkg::*;
(
    input logic clk,
    input logic rst_n,
    ltws_in_if.sink in_ch,
    ltws_out_if.source out_ch
);
    cmd_t cmd;
    stat_t stat;
    in_t item;
    out_t res;

    assign item.op = in_ch.op;
    assign item.thread_id = in_ch.thread_id;
    assign item.instr_count = in_ch.instr_count;

    ltws_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    ltws_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .item(item), .res(res), .stat(stat)
    );

    assign out_ch.slept = res.slept;
    assign out_ch.woke_valid = res.woke_valid;
    assign out_ch.woke_thread = res.woke_thread;
    assign out_ch.min_changed = res.min_changed;
    assign out_ch.is_empty = res.is_empty;
    assign out_ch.queue_full = res.queue_full;
    assign out_ch.running_now = res.running_now;
endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lockstep_thread_wake_scheduler
// Directed and random operations are driven through the operation channel.
// A predictor of the wait queue and counters queues the expected results,
// and every result transaction is compared field by field against them.
// ----------------------------------------------------------------------------
module tb;
    import ltws_pkg::*;

    localparam int TimeoutCycles = 200000;

    typedef struct {
        logic slept;
        logic woke_valid;
        logic [IdW-1:0] woke_thread;
        logic min_changed;
        logic is_empty;
        logic queue_full;
        logic [CntW-1:0] running_now;
    } sched_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ltws_in_if op_ch ();
    ltws_out_if res_ch ();

    lockstep_thread_wake_scheduler uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(op_ch.sink),
        .out_ch(res_ch.source)
    );

    always #1 clk = ~clk;

    // Scheduler state as the predictor sees it
    logic [KeyW-1:0] sleeper_keys[$];
    logic [IdW-1:0] sleeper_ids[$];
    int unsigned runners;
    logic [KeyW-1:0] min_now;
    logic [KeyW-1:0] min_reported;

    sched_result_t pending_results[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit long_hold = 1'b0;
    bit stall_enable = 1'b0;

    // Sorted insert in front of any equal keys; 0 when the queue is full
    function automatic bit enqueue_sleeper(logic [IdW-1:0] id, logic [KeyW-1:0] key);
        int pos;
        pos = 0;
        if (sleeper_keys.size() >= MaxThreads)
            return 1'b0;
        while (pos < sleeper_keys.size() && sleeper_keys[pos] < key)
            pos++;
        sleeper_keys.insert(pos, key);
        sleeper_ids.insert(pos, id);
        return 1'b1;
    endfunction

    function automatic void predict_schedule(logic [2:0] op, logic [IdW-1:0] id,
                                             logic [KeyW-1:0] key);
        sched_result_t r;
        r = '{default: '0};
        case (op)
            OP_INSERT:
            begin
                if (!enqueue_sleeper(id, key))
                    r.queue_full = 1'b1;
            end
            OP_SLEEP:
            begin
                // sole runner with nothing cheaper waiting keeps running
                if (runners == 1 && (sleeper_keys.size() == 0 || key <= sleeper_keys[0]))
                    min_now = key;
                else if (sleeper_keys.size() >= MaxThreads)
                    r.queue_full = 1'b1;
                else
                begin
                    if (runners > 0)
                        runners--;
                    void'(enqueue_sleeper(id, key));
                    r.slept = 1'b1;
                end
            end
            OP_AWAKE:
            begin
                if (sleeper_keys.size() != 0 &&
                    (runners == 0 || min_now >= sleeper_keys[0]))
                begin
                    if (runners == 0)
                        min_now = sleeper_keys[0];
                    r.woke_thread = sleeper_ids.pop_front();
                    void'(sleeper_keys.pop_front());
                    r.woke_valid = 1'b1;
                    if (runners < MaxThreads)
                        runners++;
                end
            end
            OP_RMINUS:
            begin
                if (runners > 0)
                    runners--;
            end
            OP_RPLUS:
            begin
                if (runners < MaxThreads)
                    runners++;
            end
            OP_CHANGED:
            begin
                r.min_changed = (min_now != min_reported);
                min_reported = min_now;
            end
            default:
            begin
            end
        endcase
        r.is_empty = (runners == 0 && sleeper_keys.size() == 0);
        r.running_now = runners[CntW-1:0];
        pending_results.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h, want %0h", what, got, want);
        error_count++;
    endtask

    // Sends one operation; bursts are shaped inside it through a random gap
    task automatic send_op(logic [2:0] op, logic [IdW-1:0] id, logic [KeyW-1:0] key);
        op_ch.valid <= 1'b1;
        op_ch.op <= op;
        op_ch.thread_id <= id;
        op_ch.instr_count <= key;
        @(posedge clk);
        while (!op_ch.ready)
            @(posedge clk);
        predict_schedule(op, id, key);
        @(negedge clk);
        // random gap between bursts
        if ($urandom_range(0, 5) == 0)
        begin
            op_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    function automatic logic [KeyW-1:0] random_key();
        case ($urandom_range(0, 3))
            0: return {$urandom, $urandom};
            1: return 64'(($urandom_range(0, 7)));
            2: return '1 - 64'($urandom_range(0, 3));
            default: return 64'($urandom_range(0, 40));
        endcase
    endfunction

    task automatic test_directed();
        send_op(OP_CHANGED, '0, '0);
        send_op(OP_AWAKE, '0, '0);                 // empty queue
        send_op(OP_RMINUS, '0, '0);                // floor at zero
        send_op(OP_INSERT, 4'hf, '1);
        send_op(OP_INSERT, 4'h0, '0);
        send_op(OP_INSERT, 4'h5, '0);              // goes ahead of equal key
        send_op(OP_AWAKE, '0, '0);                 // none running: pops head
        send_op(OP_SLEEP, 4'h3, 64'd0);            // sole runner stays awake
        send_op(OP_CHANGED, '0, '0);
        send_op(OP_RPLUS, '0, '0);
        send_op(OP_SLEEP, 4'ha, 64'h8000_0000_0000_0000);
        send_op(OP_AWAKE, '0, '0);
        send_op(3'd6, 4'h1, '1);
        send_op(3'd7, 4'h2, '0);
        for (int i = 0; i < MaxThreads; i++)
            send_op(OP_INSERT, 4'(i), 64'(i * 3));
        send_op(OP_INSERT, 4'h9, 64'd1);           // full queue drops insert
        repeat (MaxThreads + 2) send_op(OP_RPLUS, '0, '0);   // ceiling
        send_op(OP_SLEEP, 4'h7, 64'd100);          // full queue on sleep
        repeat (MaxThreads + 1) send_op(OP_AWAKE, '0, '0);
    endtask

    task automatic test_random(int unsigned count);
        int unsigned pick;
        for (int unsigned n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                send_op(OP_INSERT, 4'($urandom), random_key());
            else if (pick < 45)
                send_op(OP_SLEEP, 4'($urandom), random_key());
            else if (pick < 70)
                send_op(OP_AWAKE, 4'($urandom), random_key());
            else if (pick < 78)
                send_op(OP_RMINUS, 4'($urandom), random_key());
            else if (pick < 88)
                send_op(OP_RPLUS, 4'($urandom), random_key());
            else if (pick < 97)
                send_op(OP_CHANGED, 4'($urandom), random_key());
            else
                send_op(3'($urandom_range(6, 7)), 4'($urandom), random_key());
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        long_hold = 1'b1;
        fork
            test_random(40);
            begin
                repeat (60) @(negedge clk);
                long_hold = 1'b0;
            end
        join
        long_hold = 1'b0;
    endtask

    // Receiver ready pattern: stall stretches and clean stretches
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (long_hold)
            res_ch.ready <= 1'b0;
        else if (!stall_enable)
            res_ch.ready <= 1'b1;
        else
            res_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(negedge clk)
        if (cycle_count % 200 == 0)
            stall_enable <= $urandom_range(0, 1);

    // Result checker
    always @(posedge clk)
    begin
        sched_result_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                e = pending_results.pop_front();
                if (res_ch.slept !== e.slept)
                    report_mismatch("slept", res_ch.slept, e.slept);
                if (res_ch.woke_valid !== e.woke_valid)
                    report_mismatch("woke_valid", res_ch.woke_valid, e.woke_valid);
                if (res_ch.woke_thread !== e.woke_thread)
                    report_mismatch("woke_thread", res_ch.woke_thread, e.woke_thread);
                if (res_ch.min_changed !== e.min_changed)
                    report_mismatch("min_changed", res_ch.min_changed, e.min_changed);
                if (res_ch.is_empty !== e.is_empty)
                    report_mismatch("is_empty", res_ch.is_empty, e.is_empty);
                if (res_ch.queue_full !== e.queue_full)
                    report_mismatch("queue_full", res_ch.queue_full, e.queue_full);
                if (res_ch.running_now !== e.running_now)
                    report_mismatch("running_now", res_ch.running_now, e.running_now);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TimeoutCycles)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        op_ch.valid = 1'b0;
        op_ch.op = '0;
        op_ch.thread_id = '0;
        op_ch.instr_count = '0;
        res_ch.ready = 1'b0;
        runners = 0;
        min_now = '0;
        min_reported = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        test_random(560);

        op_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### lockstep_thread_wake_scheduler.f
rtl/ltws_pkg.sv
rtl/ltws_if.sv
rtl/ltws_datapath.sv
rtl/ltws_ctrl.sv
rtl/lockstep_thread_wake_scheduler.sv
bench/tb.sv
